>>> design/wsd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package wsd_pkg;

  // 7-bit length codes that announce an extended length field
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // extended-length and mask key byte counts
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  localparam logic [31:0] CAP_RESET = 32'd4096;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        message_end;
    logic [31:0] delivered_length;
  } wsd_res_t;

endpackage

>>> design/websocket_frame_deframer.sv
// WebSocket frame deframer: one received byte per item, unmasked payload out.
// A result is registered and presented in the cycle after the item that causes it.
// Throughput: one item per cycle; only a held, untaken result stalls input.
// Reset (rst_n low, synchronous): parser waits for a frame's first header
// byte, capacity returns to 4096, the output register empties.
`timescale 1ns / 1ps

module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,    // [7:0] payload_byte, [39:8] delivered_length
  output logic        out_tuser,    // byte_valid
  output logic        out_tlast,    // message_end
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data   // message_capacity
);

  logic [31:0] cap_r;
  logic        in_fire;
  logic        res_vld;
  logic        out_busy;
  wsd_res_t    res;
  wsd_res_t    out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  assign in_tready = ~out_busy;
  assign in_fire   = in_tvalid & in_tready;

  wsd_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .capacity (cap_r),
    .step     (in_fire),
    .rx_byte  (in_tdata),
    .res_vld  (res_vld),
    .res      (res)
  );

  wsd_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_fire & res_vld),
    .load_res (res),
    .take     (out_tready),
    .busy     (out_busy),
    .vld      (out_tvalid),
    .res      (out_res)
  );

  assign out_tdata = {out_res.delivered_length, out_res.payload_byte};
  assign out_tuser = out_res.byte_valid;
  assign out_tlast = out_res.message_end;

  // every presented result carries a byte, a message end, or both
  a_res_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser || out_tlast))
    else $error("result with neither byte nor message end");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[7:0] == 8'd0))
    else $error("payload byte set without byte_valid");

  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata[39:8] == 32'd0))
    else $error("delivered length set without message end");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

endmodule

>>> design/wsd_parser.sv
// Frame header parser, payload unmasking and message length accounting.
// Depends on wsd_pkg; state advances once per accepted item.
`timescale 1ns / 1ps

module wsd_parser
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] capacity,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  output logic        res_vld,
  output wsd_res_t    res
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_KEY,
    PH_DATA
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic        mask_on_r, mask_on_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        final_r, final_nxt;
  logic [31:0] room_r, room_nxt;

  logic        hdr_done;
  logic        msg_end;
  logic        deliver;
  logic [7:0]  key_byte;
  logic [6:0]  len7;

  always_comb begin
    case (pos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  assign len7 = rx_byte[6:0];

  always_comb begin
    phase_nxt   = phase_r;
    idx_nxt     = idx_r;
    rem_nxt     = rem_r;
    mask_on_nxt = mask_on_r;
    key_nxt     = key_r;
    pos_nxt     = pos_r;
    final_nxt   = final_r;
    room_nxt    = room_r;
    hdr_done    = 1'b0;
    msg_end     = 1'b0;
    deliver     = 1'b0;

    case (phase_r)
      PH_HDR0: begin
        final_nxt = rx_byte[7];
        phase_nxt = PH_HDR1;
      end
      PH_HDR1: begin
        mask_on_nxt = rx_byte[7];
        key_nxt     = '0;
        rem_nxt     = '0;
        if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
          idx_nxt   = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          phase_nxt = PH_EXT;
        end else begin
          rem_nxt = {25'd0, len7};
          if (rx_byte[7]) begin
            idx_nxt   = KEY_BYTES;
            phase_nxt = PH_KEY;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      PH_EXT: begin
        // 64-bit lengths keep only the low 32 bits
        rem_nxt = {rem_r[23:0], rx_byte};
        idx_nxt = idx_r - 4'd1;
        if (idx_nxt == 4'd0) begin
          if (mask_on_r) begin
            idx_nxt   = KEY_BYTES;
            phase_nxt = PH_KEY;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[23:0], rx_byte};
        idx_nxt = idx_r - 4'd1;
        if (idx_nxt == 4'd0) begin
          hdr_done = 1'b1;
        end
      end
      PH_DATA: begin
        pos_nxt = pos_r + 2'd1;
        if (room_r != '0) begin
          room_nxt = room_r - 32'd1;
          deliver  = 1'b1;
        end
        rem_nxt = rem_r - 32'd1;
        if (rem_nxt == '0) begin
          if (final_r) begin
            msg_end = 1'b1;
          end else begin
            phase_nxt = PH_HDR0;
          end
        end
      end
      default: begin
        phase_nxt = PH_HDR0;
      end
    endcase

    if (hdr_done) begin
      pos_nxt = 2'd0;
      if (rem_nxt != '0) begin
        phase_nxt = PH_DATA;
      end else if (final_r) begin
        msg_end = 1'b1;     // empty FIN frame ends the message here
      end else begin
        phase_nxt = PH_HDR0;
      end
    end

    res.payload_byte     = deliver ? (rx_byte ^ key_byte) : 8'd0;
    res.byte_valid       = deliver;
    res.message_end      = msg_end;
    res.delivered_length = msg_end ? (capacity - room_nxt) : 32'd0;
    res_vld              = deliver | msg_end;

    if (msg_end) begin
      room_nxt  = capacity;
      final_nxt = 1'b0;
      phase_nxt = PH_HDR0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR0;
      idx_r     <= '0;
      rem_r     <= '0;
      mask_on_r <= 1'b0;
      key_r     <= '0;
      pos_r     <= '0;
      final_r   <= 1'b0;
      room_r    <= CAP_RESET;
    end else if (step) begin
      phase_r   <= phase_nxt;
      idx_r     <= idx_nxt;
      rem_r     <= rem_nxt;
      mask_on_r <= mask_on_nxt;
      key_r     <= key_nxt;
      pos_r     <= pos_nxt;
      final_r   <= final_nxt;
      room_r    <= room_nxt;
    end
  end

endmodule

>>> design/wsd_out_reg.sv
// Result register between the parser and the output stream.
// Depends on wsd_pkg; can load when empty or while the held item is taken in the same cycle.
`timescale 1ns / 1ps

module wsd_out_reg
  import wsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  wsd_res_t load_res,
  input  logic     take,
  output logic     busy,
  output logic     vld,
  output wsd_res_t res
);

  logic     vld_r, vld_nxt;
  wsd_res_t res_r;

  // full and not drained this cycle
  assign busy = vld_r & ~take;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b0;
    end
    if (load) begin
      vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

  assign vld = vld_r;
  assign res = res_r;

endmodule
